### rtl/core/hts_pkg.sv
`timescale 1ns / 1ps

package hts_pkg;

  localparam int unsigned VERTEX_BITS     = 20;
  localparam int unsigned TETS_PER_HEXA   = 6;
  localparam int unsigned HEXA_BITS       = 20;
  localparam int unsigned TET_NUM_BITS    = 23;
  localparam int unsigned CELLS_BITS      = 11;
  localparam int unsigned POS_BITS        = 10;
  localparam int unsigned SLOT_BITS       = 3;
  localparam int unsigned CORNERS         = 8;
  localparam int unsigned CORNER_IDX_BITS = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CELLS_BITS-1:0] POS_MAX       = CELLS_BITS'(1023);
  localparam logic [CELLS_BITS-1:0] CELLS_X_RESET = CELLS_BITS'(2);
  localparam logic [CELLS_BITS-1:0] CELLS_Y_RESET = CELLS_BITS'(1);
  localparam logic [SLOT_BITS-1:0]  SLOT_LAST     = SLOT_BITS'(TETS_PER_HEXA - 1);

  typedef enum logic [1:0] {
    CFG_CELLS_X = 2'd0,
    CFG_CELLS_Y = 2'd1,
    CFG_SWAP    = 2'd2
  } cfg_idx_e;

  typedef logic [VERTEX_BITS-1:0] vertex_t;

  typedef struct packed {
    vertex_t corner_0;
    vertex_t corner_1;
    vertex_t corner_2;
    vertex_t corner_3;
    vertex_t corner_4;
    vertex_t corner_5;
    vertex_t corner_6;
    vertex_t corner_7;
  } hts_in_t;

  typedef struct packed {
    vertex_t                   tet_vertex_a;
    vertex_t                   tet_vertex_b;
    vertex_t                   tet_vertex_c;
    vertex_t                   tet_vertex_d;
    logic [HEXA_BITS-1:0]      source_hexa;
    logic [TET_NUM_BITS-1:0]   tet_number;
    logic                      last_of_hexa;
  } hts_out_t;

  typedef struct packed {
    logic [CORNERS-1:0][VERTEX_BITS-1:0] corner;
    logic                                odd;
    logic [HEXA_BITS-1:0]                hexa;
    logic [TET_NUM_BITS-1:0]             tet_base;
  } hts_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } hts_qstat_t;

  localparam logic [CORNER_IDX_BITS-1:0] PAT_PLAIN [TETS_PER_HEXA][4] = '{
    '{3'd0, 3'd5, 3'd1, 3'd6}, '{3'd0, 3'd1, 3'd3, 3'd6}, '{3'd1, 3'd3, 3'd6, 3'd2},
    '{3'd6, 3'd3, 3'd0, 3'd7}, '{3'd6, 3'd7, 3'd0, 3'd5}, '{3'd7, 3'd5, 3'd4, 3'd0}
  };

  localparam logic [CORNER_IDX_BITS-1:0] PAT_FLIPPED [TETS_PER_HEXA][4] = '{
    '{3'd0, 3'd5, 3'd6, 3'd1}, '{3'd0, 3'd1, 3'd6, 3'd3}, '{3'd1, 3'd3, 3'd2, 3'd6},
    '{3'd6, 3'd3, 3'd7, 3'd0}, '{3'd6, 3'd7, 3'd5, 3'd0}, '{3'd7, 3'd5, 3'd0, 3'd4}
  };

  function automatic logic [CORNER_IDX_BITS-1:0] pat_corner(
    input logic                 odd,
    input logic [SLOT_BITS-1:0] slot,
    input logic [1:0]           pos
  );
    logic [CORNER_IDX_BITS-1:0] idx;
    if (slot > SLOT_LAST) begin
      idx = '0;
    end else if (odd) begin
      idx = PAT_FLIPPED[slot][pos];
    end else begin
      idx = PAT_PLAIN[slot][pos];
    end
    return idx;
  endfunction

endpackage

### rtl/core/hts_front.sv
`timescale 1ns / 1ps

module hts_front
  import hts_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  input  hts_in_t               in_item_i,
  input  logic                  cfg_valid_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CELLS_BITS-1:0] cfg_data_i,
  input  hts_qstat_t            q_stat_i,
  output logic                  q_push_o,
  output hts_entry_t            q_entry_o
);

  logic [CELLS_BITS-1:0] cells_x_q, cells_x_d;
  logic [CELLS_BITS-1:0] cells_y_q, cells_y_d;
  logic                  swap_q, swap_d;
  logic [POS_BITS-1:0]   col_q, col_d;
  logic [POS_BITS-1:0]   row_q, row_d;
  logic                  layer_q, layer_d;
  logic [HEXA_BITS-1:0]  hexa_q, hexa_d;

  logic                  accept;
  logic [2:0]            flip;
  logic                  odd;
  logic [CELLS_BITS-1:0] col_next;
  logic [CELLS_BITS-1:0] row_next;
  logic                  col_wrap;
  logic                  row_wrap;
  logic [TET_NUM_BITS-1:0] hexa_ext;
  vertex_t               in_c [CORNERS];

  assign accept   = push && !q_stat_i.full;
  assign q_push_o = accept;

  assign in_c[0] = in_item_i.corner_0;
  assign in_c[1] = in_item_i.corner_1;
  assign in_c[2] = in_item_i.corner_2;
  assign in_c[3] = in_item_i.corner_3;
  assign in_c[4] = in_item_i.corner_4;
  assign in_c[5] = in_item_i.corner_5;
  assign in_c[6] = in_item_i.corner_6;
  assign in_c[7] = in_item_i.corner_7;

  // Mirroring along X swaps corner bit 0, along Y bits 0 and 1, along Z bit 2.
  always_comb begin
    flip = '0;
    odd  = 1'b0;
    if (swap_q) begin
      if (!col_q[0]) begin
        flip = flip ^ 3'd1;
        odd  = !odd;
      end
      if (row_q[0]) begin
        flip = flip ^ 3'd3;
        odd  = !odd;
      end
      if (layer_q) begin
        flip = flip ^ 3'd4;
        odd  = !odd;
      end
    end
  end

  assign hexa_ext = TET_NUM_BITS'(hexa_q);

  always_comb begin
    for (int k = 0; k < CORNERS; k++) begin
      q_entry_o.corner[k] = in_c[CORNER_IDX_BITS'(k) ^ flip];
    end
    q_entry_o.odd      = odd;
    q_entry_o.hexa     = hexa_q;
    q_entry_o.tet_base = (hexa_ext << 2) + (hexa_ext << 1);
  end

  assign col_next = CELLS_BITS'(col_q) + CELLS_BITS'(1);
  assign row_next = CELLS_BITS'(row_q) + CELLS_BITS'(1);
  assign col_wrap = (col_next >= cells_x_q) || (col_next > POS_MAX);
  assign row_wrap = (row_next >= cells_y_q) || (row_next > POS_MAX);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    layer_d = layer_q;
    hexa_d  = hexa_q;
    if (accept) begin
      hexa_d = hexa_q + HEXA_BITS'(1);
      if (col_wrap) begin
        col_d = '0;
        if (row_wrap) begin
          row_d   = '0;
          layer_d = !layer_q;
        end else begin
          row_d = row_next[POS_BITS-1:0];
        end
      end else begin
        col_d = col_next[POS_BITS-1:0];
      end
    end
  end

  always_comb begin
    cells_x_d = cells_x_q;
    cells_y_d = cells_y_q;
    swap_d    = swap_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CELLS_X: cells_x_d = cfg_data_i;
        CFG_CELLS_Y: cells_y_d = cfg_data_i;
        CFG_SWAP:    swap_d    = cfg_data_i[0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CELLS_X_RESET;
      cells_y_q <= CELLS_Y_RESET;
      swap_q    <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
      layer_q   <= 1'b0;
      hexa_q    <= '0;
    end else begin
      cells_x_q <= cells_x_d;
      cells_y_q <= cells_y_d;
      swap_q    <= swap_d;
      col_q     <= col_d;
      row_q     <= row_d;
      layer_q   <= layer_d;
      hexa_q    <= hexa_d;
    end
  end

endmodule

### rtl/core/hts_queue.sv
`timescale 1ns / 1ps

module hts_queue
  import hts_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hts_entry_t entry_i,
  input  logic       pop_i,
  output hts_entry_t head_o,
  output hts_qstat_t stat_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  hts_entry_t            mem_q [DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == CNT_FULL);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### rtl/core/hts_back.sv
`timescale 1ns / 1ps

module hts_back
  import hts_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  hts_entry_t head_i,
  input  hts_qstat_t q_stat_i,
  output logic       q_pop_o,
  input  logic       pop,
  output logic       empty,
  output hts_out_t   out_item_o
);

  logic [SLOT_BITS-1:0] slot_q, slot_d;
  logic                 out_valid_q, out_valid_d;
  hts_out_t             out_q;
  hts_out_t             res;
  logic                 load;
  logic                 take;

  assign load    = !out_valid_q || pop;
  assign take    = load && !q_stat_i.empty;
  assign q_pop_o = take && (slot_q == SLOT_LAST);

  always_comb begin
    res.tet_vertex_a = head_i.corner[pat_corner(head_i.odd, slot_q, 2'd0)];
    res.tet_vertex_b = head_i.corner[pat_corner(head_i.odd, slot_q, 2'd1)];
    res.tet_vertex_c = head_i.corner[pat_corner(head_i.odd, slot_q, 2'd2)];
    res.tet_vertex_d = head_i.corner[pat_corner(head_i.odd, slot_q, 2'd3)];
    res.source_hexa  = head_i.hexa;
    res.tet_number   = head_i.tet_base + TET_NUM_BITS'(slot_q);
    res.last_of_hexa = (slot_q == SLOT_LAST);
  end

  always_comb begin
    slot_d      = slot_q;
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
      slot_d      = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_BITS'(1);
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

endmodule

### rtl/core/hexa_to_six_tetra_split.sv
`timescale 1ns / 1ps

// Splits each hexahedron of a grid mesh into six tetrahedra. The front stage takes one
// hexahedron per beat, applies the parity-based corner mirroring when swap is set, and
// pushes it into a queue of QUEUE_DEPTH entries; the back stage reads the queue head and
// emits one tetrahedron per cycle into an output register while the queue is not empty
// and that register is free or being popped. The single result port sets the rate, and
// the queue takes new hexahedra while earlier ones are split. The first tetrahedron
// passes the queue and then the output register before it is visible. Configuration
// writes are always ready and must only be issued while no hexahedron is in flight.
module hexa_to_six_tetra_split
  import hts_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  hts_in_t               in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output hts_out_t              out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [CELLS_BITS-1:0] cfg_data_i
);

  hts_qstat_t q_stat;
  hts_entry_t q_entry;
  hts_entry_t q_head;
  logic       q_push;
  logic       q_pop;

  assign cfg_ready_o = 1'b1;
  assign full        = q_stat.full;

  hts_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .in_item_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .q_stat_i  (q_stat),
    .q_push_o  (q_push),
    .q_entry_o (q_entry)
  );

  hts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  hts_back u_back (
    .clk_i,
    .rst_ni,
    .head_i     (q_head),
    .q_stat_i   (q_stat),
    .q_pop_o    (q_pop),
    .pop,
    .empty,
    .out_item_o
  );

endmodule

### rtl/core/hts_checker.sv
`timescale 1ns / 1ps

module hts_checker
  import hts_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     empty,
  input logic     pop,
  input hts_out_t out_item_o
);

  logic [SLOT_BITS-1:0]    slot_q;
  logic [HEXA_BITS-1:0]    hexa_q;
  logic [TET_NUM_BITS-1:0] hexa_ext;
  logic                    beat;

  assign beat     = pop && !empty;
  assign hexa_ext = TET_NUM_BITS'(hexa_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      hexa_q <= '0;
    end else if (beat) begin
      if (slot_q == SLOT_LAST) begin
        slot_q <= '0;
        hexa_q <= hexa_q + HEXA_BITS'(1);
      end else begin
        slot_q <= slot_q + SLOT_BITS'(1);
      end
    end
  end

  // Every sixth beat closes a hexahedron, and only that one.
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.last_of_hexa == (slot_q == SLOT_LAST)))
    else $error("last_of_hexa out of step with beat count");

  a_source_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.source_hexa == hexa_q))
    else $error("source_hexa out of sequence");

  a_tet_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.tet_number ==
                (hexa_ext << 2) + (hexa_ext << 1) + TET_NUM_BITS'(slot_q)))
    else $error("tet_number does not match hexahedron and slot");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed before it was popped");

endmodule

bind hexa_to_six_tetra_split hts_checker u_hts_checker (
  .clk_i,
  .rst_ni,
  .empty,
  .pop,
  .out_item_o
);
